### hdl/bpa_pkg.sv
`default_nettype none

package bpa_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_PAGES  = 32768;
    localparam int DEF_WORD_BITS  = 32;
    localparam int DEF_PAGE_SHIFT = 12;

    // Fixed field widths.
    localparam int ADDR_W     = 32;
    localparam int COUNT_W    = 16;
    localparam int STATUS_W   = 2;
    localparam int S_TDATA_W  = 40;
    localparam int S_TUSER_W  = 1;
    localparam int M_TDATA_W  = 56;
    localparam int M_TUSER_W  = STATUS_W;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 32;

    localparam logic [COUNT_W-1:0] PAGE_COUNT_RESET  = 16'd32768;
    localparam logic [ADDR_W-1:0]  REGION_BASE_RESET = '0;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_PAGE_COUNT  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_REGION_BASE = 1'b1;

    typedef enum logic [0:0] {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK           = 2'd0,
        STATUS_NO_MEMORY    = 2'd1,
        STATUS_OUT_OF_RANGE = 2'd2,
        STATUS_ALREADY_FREE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_LOCATE,
        ST_FREE_CHK,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

### hdl/bpa_word_scan.sv
`default_nettype none

// Finds the lowest set bit of one bitmap word among the bits whose offset
// lies below the number of pages still available from this word on.
module bpa_word_scan #(
    parameter int WORD_BITS = 32,
    parameter int AVAIL_W   = 17
) (
    input  wire logic [WORD_BITS-1:0]           word_i,
    input  wire logic [AVAIL_W-1:0]             avail_i,
    output logic                                found_o,
    output logic [$clog2(WORD_BITS)-1:0]        bit_o
);

    localparam int BIT_W = $clog2(WORD_BITS);

    always_comb begin
        found_o = 1'b0;
        bit_o   = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (word_i[b] && (AVAIL_W'(b) < avail_i)) begin
                found_o = 1'b1;
                bit_o   = BIT_W'(b);
            end
        end
    end

endmodule

`default_nettype wire

### hdl/bitmap_page_allocator.sv
`default_nettype none

// Channel  | Dir | Handshake             | Payload
// ---------+-----+-----------------------+---------------------------------------------
// s_       | in  | s_tvalid / s_tready   | tuser: operation; tdata: page_address,
//          |     |                       |   zero_fill
// m_       | out | m_tvalid / m_tready   | tuser: status; tdata: granted_address,
//          |     |                       |   clear_page, free_pages
// cfg_     | in  | cfg_wr_en (no wait)   | cfg_index, cfg_wr_data
//
// An allocate request walks the bitmap one word per cycle through a single
// word-scan unit, fed by a memory with a registered read port. The word with
// the grant is written back with that page's bit cleared, and the result goes
// through ST_DONE to the result register; a full miss scans every word whose
// first page lies below page_count, up to WORD_COUNT words (1024 at the defaults).
// A free request splits the page number into word and bit by shift and mask,
// then reads and checks the word of an in-range page, and writes it back if in use.
// After reset a clearing pass marks every page free, one word a cycle, over
// WORD_COUNT words (1024 at the defaults); requests wait, configuration
// writes are taken. One request is in work at a time; the result register
// lets the next request be taken while the last result waits on m_tready.
module bitmap_page_allocator #(
    parameter int MAX_PAGES  = bpa_pkg::DEF_MAX_PAGES,
    parameter int WORD_BITS  = bpa_pkg::DEF_WORD_BITS,
    parameter int PAGE_SHIFT = bpa_pkg::DEF_PAGE_SHIFT
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [31:0] page_address, [32] zero_fill, [39:33] zero
    input  wire logic [bpa_pkg::S_TDATA_W-1:0]     s_tdata,
    // [0] operation
    input  wire logic [bpa_pkg::S_TUSER_W-1:0]     s_tuser,

    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [31:0] granted_address, [32] clear_page, [48:33] free_pages, [55:49] zero
    output logic [bpa_pkg::M_TDATA_W-1:0]          m_tdata,
    // [1:0] status
    output logic [bpa_pkg::M_TUSER_W-1:0]          m_tuser,

    input  wire logic                              cfg_wr_en,
    input  wire logic [bpa_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [bpa_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);

    import bpa_pkg::*;

    localparam int WORD_COUNT = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int WIDX_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int WCNT_W     = $clog2(WORD_COUNT + 1);
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int PG_W       = $clog2(MAX_PAGES);
    localparam int BASE_W     = $clog2((WORD_COUNT + 1) * WORD_BITS + 1);
    localparam int CMP_W      = (BASE_W > COUNT_W + 1) ? BASE_W : COUNT_W + 1;
    localparam int PAD_W      = M_TDATA_W - ADDR_W - 1 - COUNT_W;

    // Bitmap memory: a set bit marks a free page.
    logic [WORD_BITS-1:0] bitmap_mem [WORD_COUNT];
    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 mem_we;
    logic [WIDX_W-1:0]    mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [WIDX_W-1:0]    rd_addr;

    // Sequencer state.
    state_t               state_reg, state_next;
    logic [WCNT_W-1:0]    widx_reg, widx_next;
    logic [BASE_W-1:0]    base_reg, base_next;
    logic                 chk_valid_reg, chk_valid_next;
    logic [WIDX_W-1:0]    chk_idx_reg, chk_idx_next;
    logic [BASE_W-1:0]    chk_base_reg, chk_base_next;
    logic [PG_W-1:0]      page_reg, page_next;
    logic [BIT_W-1:0]     bit_reg, bit_next;
    logic                 zero_fill_reg, zero_fill_next;
    logic                 grant_reg, grant_next;
    status_t              res_status_reg, res_status_next;
    logic [COUNT_W-1:0]   used_count_reg, used_count_next;

    // Configuration.
    logic [COUNT_W-1:0]   page_count_reg;
    logic [ADDR_W-1:0]    region_base_reg;

    // Result register.
    logic                 m_tvalid_reg, m_tvalid_next;
    status_t              out_status_reg, out_status_next;
    logic [ADDR_W-1:0]    out_granted_reg, out_granted_next;
    logic                 out_clear_reg, out_clear_next;
    logic [COUNT_W-1:0]   out_free_reg, out_free_next;

    // Datapath.
    logic [COUNT_W-1:0]   eff_count;
    logic [COUNT_W-1:0]   free_left;
    logic                 s_accept;
    op_t                  in_op;
    logic [ADDR_W-1:0]    in_addr;
    logic                 in_zero;
    logic [ADDR_W-1:0]    in_page;
    logic                 issue_ok;
    logic [CMP_W-1:0]     avail;
    logic                 scan_found;
    logic [BIT_W-1:0]     scan_bit;
    logic                 out_free;
    logic [COUNT_W-1:0]   used_inc;
    logic [COUNT_W-1:0]   used_dec;
    logic [ADDR_W-1:0]    grant_addr;

    // A page_count above the bitmap size acts as the bitmap size.
    assign eff_count = (ADDR_W'(page_count_reg) > ADDR_W'(MAX_PAGES)) ?
                       COUNT_W'(MAX_PAGES) : page_count_reg;

    // Pages in use can exceed the count when page_count was lowered later.
    assign free_left = (used_count_reg > eff_count) ? '0 : eff_count - used_count_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign in_op    = op_t'(s_tuser[0]);
    assign in_addr  = s_tdata[ADDR_W-1:0];
    assign in_zero  = s_tdata[ADDR_W];

    // The offset wraps modulo 2^32, so addresses below the region land high.
    assign in_page  = (in_addr - region_base_reg) >> PAGE_SHIFT;

    // A word is worth reading while its first page lies below the count.
    assign issue_ok = CMP_W'(base_reg) < CMP_W'(eff_count);
    assign avail    = CMP_W'(eff_count) - CMP_W'(chk_base_reg);
    assign out_free = !m_tvalid_reg || m_tready;

    assign used_inc = (used_count_reg == '1) ? used_count_reg : used_count_reg + 1'b1;
    assign used_dec = (used_count_reg == '0) ? used_count_reg : used_count_reg - 1'b1;

    assign grant_addr = region_base_reg + (ADDR_W'(page_reg) << PAGE_SHIFT);

    assign rd_addr = widx_reg[WIDX_W-1:0];

    bpa_word_scan #(
        .WORD_BITS (WORD_BITS),
        .AVAIL_W   (CMP_W)
    ) u_word_scan (
        .word_i  (rd_data_reg),
        .avail_i (avail),
        .found_o (scan_found),
        .bit_o   (scan_bit)
    );

    // Next-state and datapath control.
    always_comb begin
        state_next      = state_reg;
        widx_next       = widx_reg;
        base_next       = base_reg;
        chk_valid_next  = chk_valid_reg;
        chk_idx_next    = chk_idx_reg;
        chk_base_next   = chk_base_reg;
        page_next       = page_reg;
        bit_next        = bit_reg;
        zero_fill_next  = zero_fill_reg;
        grant_next      = grant_reg;
        res_status_next = res_status_reg;
        used_count_next = used_count_reg;

        m_tvalid_next    = m_tvalid_reg && !m_tready;
        out_status_next  = out_status_reg;
        out_granted_next = out_granted_reg;
        out_clear_next   = out_clear_reg;
        out_free_next    = out_free_reg;

        mem_we    = 1'b0;
        mem_waddr = widx_reg[WIDX_W-1:0];
        mem_wdata = '1;

        unique case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = widx_reg[WIDX_W-1:0];
                mem_wdata = '1;
                if (widx_reg == WCNT_W'(WORD_COUNT - 1)) begin
                    widx_next  = '0;
                    state_next = ST_IDLE;
                end else begin
                    widx_next = widx_reg + 1'b1;
                end
            end

            ST_IDLE: begin
                if (s_accept) begin
                    zero_fill_next = in_zero;
                    widx_next      = '0;
                    base_next      = '0;
                    chk_valid_next = 1'b0;
                    grant_next     = 1'b0;
                    if (in_op == OP_ALLOC) begin
                        state_next = ST_SCAN;
                    end else if (in_page >= ADDR_W'(eff_count)) begin
                        res_status_next = STATUS_OUT_OF_RANGE;
                        state_next      = ST_DONE;
                    end else begin
                        // Word index and bit offset of the page, by shift and mask.
                        page_next  = PG_W'(in_page);
                        widx_next  = WCNT_W'(in_page >> BIT_W);
                        bit_next   = in_page[BIT_W-1:0];
                        state_next = ST_LOCATE;
                    end
                end
            end

            ST_SCAN: begin
                // One word is read while the word read last cycle is checked.
                chk_valid_next = issue_ok;
                chk_idx_next   = widx_reg[WIDX_W-1:0];
                chk_base_next  = base_reg;
                if (issue_ok) begin
                    widx_next = widx_reg + 1'b1;
                    base_next = base_reg + BASE_W'(WORD_BITS);
                end
                if (chk_valid_reg && scan_found) begin
                    mem_we          = 1'b1;
                    mem_waddr       = chk_idx_reg;
                    mem_wdata       = rd_data_reg & ~(WORD_BITS'(1) << scan_bit);
                    page_next       = PG_W'(chk_base_reg + BASE_W'(scan_bit));
                    used_count_next = used_inc;
                    grant_next      = 1'b1;
                    res_status_next = STATUS_OK;
                    state_next      = ST_DONE;
                end else if (!issue_ok) begin
                    res_status_next = STATUS_NO_MEMORY;
                    state_next      = ST_DONE;
                end
            end

            ST_LOCATE: begin
                // The word that holds the page is read in this cycle.
                state_next = ST_FREE_CHK;
            end

            ST_FREE_CHK: begin
                if (rd_data_reg[bit_reg]) begin
                    res_status_next = STATUS_ALREADY_FREE;
                end else begin
                    mem_we          = 1'b1;
                    mem_waddr       = widx_reg[WIDX_W-1:0];
                    mem_wdata       = rd_data_reg | (WORD_BITS'(1) << bit_reg);
                    used_count_next = used_dec;
                    res_status_next = STATUS_OK;
                end
                state_next = ST_DONE;
            end

            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next    = 1'b1;
                    out_status_next  = res_status_reg;
                    out_granted_next = grant_reg ? grant_addr : '0;
                    out_clear_next   = grant_reg && zero_fill_reg;
                    out_free_next    = free_left;
                    state_next       = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Control registers and configuration.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            widx_reg        <= '0;
            chk_valid_reg   <= 1'b0;
            used_count_reg  <= '0;
            m_tvalid_reg    <= 1'b0;
            page_count_reg  <= PAGE_COUNT_RESET;
            region_base_reg <= REGION_BASE_RESET;
        end else begin
            widx_reg       <= widx_next;
            chk_valid_reg  <= chk_valid_next;
            used_count_reg <= used_count_next;
            m_tvalid_reg   <= m_tvalid_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_PAGE_COUNT:  page_count_reg  <= cfg_wr_data[COUNT_W-1:0];
                    CFG_REGION_BASE: region_base_reg <= cfg_wr_data[ADDR_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        base_reg        <= base_next;
        chk_idx_reg     <= chk_idx_next;
        chk_base_reg    <= chk_base_next;
        page_reg        <= page_next;
        bit_reg         <= bit_next;
        zero_fill_reg   <= zero_fill_next;
        grant_reg       <= grant_next;
        res_status_reg  <= res_status_next;
        out_status_reg  <= out_status_next;
        out_granted_reg <= out_granted_next;
        out_clear_reg   <= out_clear_next;
        out_free_reg    <= out_free_next;
    end

    // Bitmap memory with one write port and a registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            bitmap_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= bitmap_mem[rd_addr];
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {PAD_W'(0), out_free_reg, out_clear_reg, out_granted_reg};

endmodule

`default_nettype wire
